/* sv/hrbt_pkg.sv */
// shared types, constants and tables of the http request byte tokenizer
`timescale 1ns / 1ps
`default_nettype none
package hrbt_pkg;

	localparam int LENGTH_BITS  = 32;
	localparam int METHOD_COUNT = 8;

	typedef enum logic [3:0] {
		PH_METHOD       = 4'd0,
		PH_AFTER_METHOD = 4'd1,
		PH_URI_PRE      = 4'd2,
		PH_URI          = 4'd3,
		PH_VER_PRE      = 4'd4,
		PH_VERSION      = 4'd5,
		PH_REQ_END      = 4'd6,
		PH_NAME         = 4'd7,
		PH_VAL_OWS      = 4'd8,
		PH_VALUE        = 4'd9,
		PH_BODY         = 4'd10,
		PH_DROP         = 4'd11
	} phase_t;

	typedef enum logic [3:0] {
		ROLE_METHOD  = 4'd0,
		ROLE_SPACE   = 4'd1,
		ROLE_URI     = 4'd2,
		ROLE_VERSION = 4'd3,
		ROLE_EOL     = 4'd4,
		ROLE_NAME    = 4'd5,
		ROLE_VALUE   = 4'd6,
		ROLE_BODY    = 4'd7,
		ROLE_DROP    = 4'd8,
		ROLE_BLANK   = 4'd9
	} role_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_METHOD  = 2'd1,
		ERR_VERSION = 2'd2
	} err_t;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// method names padded with spaces past their length
	localparam logic [0:6][7:0] METH_TEXT [8] = '{
		"OPTIONS", "GET    ", "HEAD   ", "POST   ",
		"PUT    ", "DELETE ", "TRACE  ", "CONNECT"
	};
	localparam logic [3:0] METH_LEN [8] = '{
		4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
	};

	localparam int          HDR_LEN  = 14;
	localparam logic [0:13][7:0] HDR_TEXT = "content-length";
	localparam int          VER_LEN  = 5;
	localparam logic [0:4][7:0]  VER_TEXT = "HTTP/";

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// clamp the accumulator to the 32-bit result field
	function automatic logic [31:0] sat32(input logic [LENGTH_BITS-1:0] v);
		logic [LENGTH_BITS+31:0] ext;
		logic [31:0] r;
		ext = (LENGTH_BITS + 32)'(v);
		if (ext > (LENGTH_BITS + 32)'(32'hffff_ffff)) begin
			r = 32'hffff_ffff;
		end else begin
			r = ext[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/http_request_byte_tokenizer.sv */
// http request byte tokenizer: tags every byte of a request stream with its role
// One byte in, one result word out, one word per clock sustained while the
// result side does not stall. A word taken on the input channel sits in an
// input register; the parser state and a short decode of that byte (method
// table match, version check, header name compare, a times-ten add for
// content-length) produce the result word, which is loaded into the output
// register once that register is free and is held there until taken. The
// output register frees the input side, so a new byte is taken every cycle as
// long as the result is drained; the input stalls only while a result is held
// and the byte behind it has nowhere to go. request_start clears all
// per-request state before its byte is parsed as the first method byte.
// After an error, or once a request is done, bytes are dropped until the next
// request_start. The content-length accumulator saturates at all ones.
`timescale 1ns / 1ps
`default_nettype none
module http_request_byte_tokenizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        request_start,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       byte_role,
	output logic             token_last,
	output logic [3:0]       method_code,
	output logic [3:0]       version_major,
	output logic [3:0]       version_minor,
	output logic [31:0]      body_length,
	output logic [1:0]       error_code,
	output logic             request_done
);
	import hrbt_pkg::*;

	// handshake / pipeline control
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;
	logic       out_valid_q;
	logic       out_load;
	logic       advance;

	// parser state
	phase_t                  phase_q,   phase_d;
	logic [METHOD_COUNT-1:0] cand_q,    cand_d;
	logic [2:0]              mpos_q,    mpos_d;
	logic [3:0]              method_q,  method_d;
	logic [2:0]              vpos_q,    vpos_d;
	logic [3:0]              major_q,   major_d;
	logic [3:0]              minor_q,   minor_d;
	logic [3:0]              nidx_q,    nidx_d;
	logic                    nmatch_q,  nmatch_d;
	logic                    lenseen_q, lenseen_d;
	logic [LENGTH_BITS-1:0]  acc_q,     acc_d;
	logic [LENGTH_BITS-1:0]  remain_q,  remain_d;
	logic                    empty_q,   empty_d;
	err_t                    err_q,     err_d;

	// per-byte outputs
	role_t role_c;
	logic  last_c;
	logic  done_c;

	// result register
	role_t       role_q;
	logic        last_q;
	logic [3:0]  method_out_q;
	logic [3:0]  major_out_q;
	logic [3:0]  minor_out_q;
	logic [31:0] length_out_q;
	err_t        err_out_q;
	logic        done_q;

	// output register empties or is taken this cycle
	assign out_load = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_load;
	// the input register moves on whenever its word advances
	assign in_stall = valid_s1 && !out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1  <= data_byte;
			start_s1 <= request_start;
		end
	end

	// next-state and per-byte decode
	always_comb begin
		phase_t                  ph;
		logic [METHOD_COUNT-1:0] cand;
		logic [2:0]              mpos;
		logic [2:0]              vpos;
		logic [LENGTH_BITS-1:0]  acc;
		logic [LENGTH_BITS+3:0]  acc10;
		logic [METHOD_COUNT-1:0] keep;
		logic [3:0]              hit;
		logic [7:0]              b;
		logic                    cr;
		logic                    lf;
		logic                    sp;
		logic                    dig;
		logic                    ver_fail;
		logic                    do_ver;
		logic                    do_val;
		logic                    line_end;

		b  = data_s1;
		cr = (b == CH_CR);
		lf = (b == CH_LF);
		sp = (b == CH_SP);
		dig = is_digit(b);
		ver_fail = 1'b0;
		do_ver   = 1'b0;
		do_val   = 1'b0;
		line_end = 1'b0;
		keep = '0;
		hit  = 4'd0;

		// request_start wipes the request before this byte is parsed
		if (start_s1) begin
			ph        = PH_METHOD;
			cand      = '1;
			mpos      = 3'd0;
			method_d  = 4'd0;
			vpos      = 3'd0;
			major_d   = 4'd0;
			minor_d   = 4'd0;
			lenseen_d = 1'b0;
			acc       = '0;
			remain_d  = '0;
			err_d     = ERR_NONE;
			nidx_d    = 4'd0;
			nmatch_d  = 1'b1;
			empty_d   = 1'b1;
		end else begin
			ph        = phase_q;
			cand      = cand_q;
			mpos      = mpos_q;
			method_d  = method_q;
			vpos      = vpos_q;
			major_d   = major_q;
			minor_d   = minor_q;
			lenseen_d = lenseen_q;
			acc       = acc_q;
			remain_d  = remain_q;
			err_d     = err_q;
			nidx_d    = nidx_q;
			nmatch_d  = nmatch_q;
			empty_d   = empty_q;
		end

		phase_d = ph;
		cand_d  = cand;
		mpos_d  = mpos;
		vpos_d  = vpos;
		acc_d   = acc;
		role_c  = ROLE_DROP;
		last_c  = 1'b0;
		done_c  = 1'b0;

		// parallel compare against every method name still in the running
		for (int i = METHOD_COUNT - 1; i >= 0; i--) begin
			if (cand[i] && ({1'b0, mpos} < METH_LEN[i]) && (METH_TEXT[i][mpos] == b)) begin
				if ({1'b0, mpos} + 4'd1 == METH_LEN[i]) begin
					hit = 4'(i + 1);
				end else begin
					keep[i] = 1'b1;
				end
			end
		end

		// times ten plus digit, saturating
		acc10 = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (LENGTH_BITS + 4)'(b - CH_ZERO);

		unique case (ph)
			PH_METHOD: begin
				if (hit != 4'd0) begin
					method_d = hit;
					role_c   = ROLE_METHOD;
					last_c   = 1'b1;
					phase_d  = PH_AFTER_METHOD;
				end else if (keep == '0) begin
					err_d   = ERR_METHOD;
					phase_d = PH_DROP;
				end else begin
					role_c = ROLE_METHOD;
					cand_d = keep;
					mpos_d = mpos + 3'd1;
				end
			end
			PH_AFTER_METHOD: begin
				if (sp) begin
					role_c  = ROLE_SPACE;
					phase_d = PH_URI_PRE;
				end else begin
					err_d   = ERR_METHOD;
					phase_d = PH_DROP;
				end
			end
			PH_URI_PRE: begin
				if (sp) begin
					role_c = ROLE_SPACE;
				end else if (cr || lf) begin
					err_d   = ERR_VERSION;
					phase_d = PH_DROP;
				end else begin
					role_c  = ROLE_URI;
					phase_d = PH_URI;
				end
			end
			PH_URI: begin
				if (sp) begin
					role_c  = ROLE_SPACE;
					last_c  = 1'b1;
					phase_d = PH_VER_PRE;
				end else if (cr || lf) begin
					err_d   = ERR_VERSION;
					phase_d = PH_DROP;
				end else begin
					role_c = ROLE_URI;
				end
			end
			PH_VER_PRE: begin
				if (sp) begin
					role_c = ROLE_SPACE;
				end else begin
					phase_d = PH_VERSION;
					do_ver  = 1'b1;
				end
			end
			PH_VERSION: begin
				do_ver = 1'b1;
			end
			PH_REQ_END: begin
				if (sp) begin
					role_c = ROLE_SPACE;
				end else if (cr) begin
					role_c = ROLE_EOL;
				end else if (lf) begin
					role_c   = ROLE_EOL;
					last_c   = 1'b1;
					phase_d  = PH_NAME;
					nidx_d   = 4'd0;
					nmatch_d = 1'b1;
					empty_d  = 1'b1;
				end else begin
					err_d   = ERR_VERSION;
					phase_d = PH_DROP;
				end
			end
			PH_NAME: begin
				if (cr) begin
					role_c = empty_d ? ROLE_BLANK : ROLE_EOL;
				end else if (lf) begin
					line_end = 1'b1;
				end else if (b == CH_COLON) begin
					role_c  = ROLE_NAME;
					last_c  = 1'b1;
					empty_d = 1'b0;
					phase_d = PH_VAL_OWS;
					if (nmatch_d && nidx_d == 4'(HDR_LEN)) begin
						// only the first content-length header counts
						if (lenseen_d) begin
							nmatch_d = 1'b0;
						end else begin
							lenseen_d = 1'b1;
							acc_d     = '0;
						end
					end else begin
						nmatch_d = 1'b0;
					end
				end else begin
					role_c  = ROLE_NAME;
					empty_d = 1'b0;
					if (nmatch_d) begin
						if (nidx_d < 4'(HDR_LEN) && to_lower(b) == HDR_TEXT[nidx_d]) begin
							nidx_d = nidx_d + 4'd1;
						end else begin
							nmatch_d = 1'b0;
						end
					end
				end
			end
			PH_VAL_OWS: begin
				if (sp || b == CH_TAB) begin
					role_c = ROLE_SPACE;
				end else if (cr) begin
					role_c = ROLE_EOL;
				end else if (lf) begin
					line_end = 1'b1;
				end else begin
					phase_d = PH_VALUE;
					do_val  = 1'b1;
				end
			end
			PH_VALUE: begin
				if (cr) begin
					role_c   = ROLE_EOL;
					nmatch_d = 1'b0;
				end else if (lf) begin
					line_end = 1'b1;
				end else begin
					do_val = 1'b1;
				end
			end
			PH_BODY: begin
				role_c   = ROLE_BODY;
				remain_d = remain_d - 1'b1;
				if (remain_d == '0) begin
					last_c  = 1'b1;
					done_c  = 1'b1;
					phase_d = PH_DROP;
				end
			end
			default: begin
				role_c  = ROLE_DROP;
				phase_d = PH_DROP;
			end
		endcase

		// HTTP/d.d, one character per byte
		if (do_ver) begin
			role_c = ROLE_VERSION;
			if (vpos < 3'(VER_LEN)) begin
				ver_fail = (b != VER_TEXT[vpos]);
			end else if (vpos == 3'd5) begin
				ver_fail = !dig;
				if (dig) begin
					major_d = b[3:0];
				end
			end else if (vpos == 3'd6) begin
				ver_fail = (b != CH_DOT);
			end else begin
				ver_fail = !dig;
				if (dig) begin
					minor_d = b[3:0];
					last_c  = 1'b1;
					phase_d = PH_REQ_END;
				end
			end
			if (ver_fail) begin
				role_c  = ROLE_DROP;
				err_d   = ERR_VERSION;
				phase_d = PH_DROP;
			end else begin
				vpos_d = vpos + 3'd1;
			end
		end

		// header value byte, digits feed the length while the name matched
		if (do_val) begin
			role_c  = ROLE_VALUE;
			empty_d = 1'b0;
			if (nmatch_d && nidx_d == 4'(HDR_LEN)) begin
				if (dig) begin
					if (acc10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
						acc_d = '1;
					end else begin
						acc_d = acc10[LENGTH_BITS-1:0];
					end
				end else begin
					nmatch_d = 1'b0;
				end
			end
		end

		// lf in the header section: blank line ends it
		if (line_end) begin
			last_c = 1'b1;
			if (empty_d) begin
				role_c = ROLE_BLANK;
				if (lenseen_d && acc_d != '0) begin
					remain_d = acc_d;
					phase_d  = PH_BODY;
				end else begin
					done_c  = 1'b1;
					phase_d = PH_DROP;
				end
			end else begin
				role_c  = ROLE_EOL;
				phase_d = PH_NAME;
			end
			nidx_d   = 4'd0;
			nmatch_d = 1'b1;
			empty_d  = 1'b1;
		end
	end

	// parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_METHOD;
			cand_q    <= '1;
			mpos_q    <= 3'd0;
			method_q  <= 4'd0;
			vpos_q    <= 3'd0;
			major_q   <= 4'd0;
			minor_q   <= 4'd0;
			nidx_q    <= 4'd0;
			nmatch_q  <= 1'b1;
			lenseen_q <= 1'b0;
			acc_q     <= '0;
			remain_q  <= '0;
			empty_q   <= 1'b1;
			err_q     <= ERR_NONE;
		end else if (advance) begin
			phase_q   <= phase_d;
			cand_q    <= cand_d;
			mpos_q    <= mpos_d;
			method_q  <= method_d;
			vpos_q    <= vpos_d;
			major_q   <= major_d;
			minor_q   <= minor_d;
			nidx_q    <= nidx_d;
			nmatch_q  <= nmatch_d;
			lenseen_q <= lenseen_d;
			acc_q     <= acc_d;
			remain_q  <= remain_d;
			empty_q   <= empty_d;
			err_q     <= err_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			role_q       <= role_c;
			last_q       <= last_c;
			method_out_q <= method_d;
			major_out_q  <= major_d;
			minor_out_q  <= minor_d;
			length_out_q <= sat32(acc_d);
			err_out_q    <= err_d;
			done_q       <= done_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_role     = role_q;
	assign token_last    = last_q;
	assign method_code   = method_out_q;
	assign version_major = major_out_q;
	assign version_minor = minor_out_q;
	assign body_length   = length_out_q;
	assign error_code    = err_out_q;
	assign request_done  = done_q;

	// a flagged error always comes with a dropped byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> byte_role == ROLE_DROP)
		else $error("error word not tagged as dropped");

	// completion only on an error-free request, and it closes a token
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_done |-> error_code == ERR_NONE && token_last)
		else $error("request done with error or without token end");

	// body phase never holds a spent count
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> remain_q != '0)
		else $error("body phase with zero bytes left");

	// a stalled result word is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_role) && $stable(body_length))
		else $error("stalled result word changed");

endmodule
`default_nettype wire

/* bench/http_request_byte_tokenizer_tb.sv */
// self-checking testbench for the http request byte tokenizer, with its own byte-role predictor
`timescale 1ns / 1ps
module http_request_byte_tokenizer_tb;
	import hrbt_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_WORDS  = 1950;
	localparam int REPORT_LIMIT  = 10;
	localparam int TAIL_CYCLES   = 10;
	localparam int DRAIN_EVERY   = 50;

	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7a;

	// method names right-aligned in 56 bits, first character in the highest used byte
	localparam logic [55:0] METHOD_NAME [8] = '{
		"OPTIONS", "GET", "HEAD", "POST", "PUT", "DELETE", "TRACE", "CONNECT"
	};
	localparam int METHOD_LEN [8] = '{7, 3, 4, 4, 3, 6, 5, 7};
	localparam logic [111:0] LENGTH_TAG  = "content-length";
	localparam logic [39:0]  VERSION_TAG = "HTTP/";

	// one result word as the block presents it
	typedef struct packed {
		role_t       role;
		logic        last;
		logic [3:0]  method;
		logic [3:0]  major;
		logic [3:0]  minor;
		logic [31:0] length;
		err_t        err;
		logic        done;
	} token_word_t;

	// one row of the directed table; typed rows carry their own expected word
	typedef struct {
		logic [7:0]  b;
		logic        start;
		logic        typed;
		token_word_t want;
	} stim_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	// dut connections, every input known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        request_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  byte_role;
	logic        token_last;
	logic [3:0]  method_code;
	logic [3:0]  version_major;
	logic [3:0]  version_minor;
	logic [31:0] body_length;
	logic [1:0]  error_code;
	logic        request_done;

	// typed expectation travels with the word, held like the payload
	logic        row_typed = 1'b0;
	token_word_t row_want = '0;

	// predictor state
	phase_t                 prs_phase;
	logic [7:0]             prs_cands;
	logic [2:0]             prs_mpos;
	logic [3:0]             prs_method;
	logic [2:0]             prs_vpos;
	logic [3:0]             prs_major;
	logic [3:0]             prs_minor;
	logic [3:0]             prs_name_idx;
	logic                   prs_name_ok;
	logic                   prs_len_seen;
	logic                   prs_line_empty;
	logic [LENGTH_BITS-1:0] prs_len;
	logic [LENGTH_BITS-1:0] prs_remaining;
	err_t                   prs_err;
	role_t                  cur_role;
	logic                   cur_last;
	logic                   cur_done;

	token_word_t expected_words [$];
	stim_row_t   directed_rows [$];
	logic [7:0]  request_bytes [$];
	logic        request_starts [$];

	// bookkeeping
	int          cycle_count = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          mismatches = 0;
	int          n_results = 0;
	int          n_sent = 0;
	int          n_parsed = 0;
	int          n_requests = 0;
	int          n_done = 0;
	int          n_body = 0;
	int          n_blank = 0;
	int          n_bad_method = 0;
	int          n_bad_version = 0;
	token_word_t seen_word;
	token_word_t want_word;
	string       bad_fields;

	http_request_byte_tokenizer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.request_start (request_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_role     (byte_role),
		.token_last    (token_last),
		.method_code   (method_code),
		.version_major (version_major),
		.version_minor (version_minor),
		.body_length   (body_length),
		.error_code    (error_code),
		.request_done  (request_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// header-line matching restarts at every line
	function automatic void start_line();
		prs_name_idx   = 4'd0;
		prs_name_ok    = 1'b1;
		prs_line_empty = 1'b1;
	endfunction

	// everything a request_start (or reset) wipes
	function automatic void clear_parser();
		prs_phase     = PH_METHOD;
		prs_cands     = 8'((1 << METHOD_COUNT) - 1);
		prs_mpos      = 3'd0;
		prs_method    = 4'd0;
		prs_vpos      = 3'd0;
		prs_major     = 4'd0;
		prs_minor     = 4'd0;
		prs_len_seen  = 1'b0;
		prs_len       = '0;
		prs_remaining = '0;
		prs_err       = ERR_NONE;
		start_line();
	endfunction

	// latch the error and drop everything until the next request_start
	function automatic void enter_drop(input err_t code);
		prs_err   = code;
		cur_role  = ROLE_DROP;
		prs_phase = PH_DROP;
	endfunction

	// lf closes a line; an empty line closes the header section
	function automatic void end_line();
		cur_last = 1'b1;
		if (prs_line_empty) begin
			cur_role = ROLE_BLANK;
			if (prs_len_seen && prs_len != 0) begin
				prs_remaining = prs_len;
				prs_phase     = PH_BODY;
			end else begin
				cur_done  = 1'b1;
				prs_phase = PH_DROP;
			end
		end else begin
			cur_role  = ROLE_EOL;
			prs_phase = PH_NAME;
		end
		start_line();
	endfunction

	// HTTP/d.d, one position per byte
	function automatic void version_byte(input logic [7:0] b);
		logic dig;
		logic ok;
		dig = (b >= CH_ZERO) && (b <= CH_NINE);
		case (prs_vpos)
			3'd5: ok = dig;
			3'd6: ok = (b == CH_DOT);
			3'd7: ok = dig;
			default: ok = (b == VERSION_TAG[8*(4-prs_vpos) +: 8]);
		endcase
		if (!ok) begin
			enter_drop(ERR_VERSION);
		end else begin
			cur_role = ROLE_VERSION;
			if (prs_vpos == 3'd5) begin
				prs_major = 4'(b - CH_ZERO);
			end
			if (prs_vpos == 3'd7) begin
				prs_minor = 4'(b - CH_ZERO);
				cur_last  = 1'b1;
				prs_phase = PH_REQ_END;
			end
			prs_vpos = prs_vpos + 3'd1;
		end
	endfunction

	// value byte; only the first content-length value feeds the length, up to a non-digit
	function automatic void value_byte(input logic [7:0] b);
		logic [LENGTH_BITS+3:0] grown;
		logic [LENGTH_BITS+3:0] digit;
		cur_role       = ROLE_VALUE;
		prs_line_empty = 1'b0;
		if (prs_name_ok && prs_name_idx == 4'd14) begin
			if (b >= CH_ZERO && b <= CH_NINE) begin
				grown = prs_len;
				digit = b - CH_ZERO;
				grown = grown * 10 + digit;
				// saturate instead of wrapping
				if (grown[LENGTH_BITS+3:LENGTH_BITS] != 0) begin
					prs_len = '1;
				end else begin
					prs_len = grown[LENGTH_BITS-1:0];
				end
			end else begin
				prs_name_ok = 1'b0;
			end
		end
	endfunction

	// expected result word for one accepted input word
	function automatic token_word_t predict_word(input logic [7:0] b, input logic start);
		logic        is_cr;
		logic        is_lf;
		logic        is_sp;
		logic [7:0]  keep;
		logic [3:0]  hit;
		logic [7:0]  folded;
		token_word_t w;
		is_cr = (b == CH_CR);
		is_lf = (b == CH_LF);
		is_sp = (b == CH_SP);
		if (start) begin
			clear_parser();
		end
		cur_role = ROLE_DROP;
		cur_last = 1'b0;
		cur_done = 1'b0;
		case (prs_phase)
			PH_METHOD: begin
				// narrow the surviving method names by one character
				keep = '0;
				hit  = 4'd0;
				for (int i = 0; i < METHOD_COUNT; i++) begin
					if (prs_cands[i] && prs_mpos < METHOD_LEN[i] &&
					    METHOD_NAME[i][8*(METHOD_LEN[i]-1-prs_mpos) +: 8] == b) begin
						if (prs_mpos + 1 == METHOD_LEN[i]) begin
							if (hit == 0) begin
								hit = 4'(i + 1);
							end
						end else begin
							keep[i] = 1'b1;
						end
					end
				end
				if (hit != 0) begin
					prs_method = hit;
					cur_role   = ROLE_METHOD;
					cur_last   = 1'b1;
					prs_phase  = PH_AFTER_METHOD;
				end else if (keep == 0) begin
					enter_drop(ERR_METHOD);
				end else begin
					cur_role  = ROLE_METHOD;
					prs_cands = keep;
					prs_mpos  = prs_mpos + 3'd1;
				end
			end
			PH_AFTER_METHOD: begin
				if (is_sp) begin
					cur_role  = ROLE_SPACE;
					prs_phase = PH_URI_PRE;
				end else begin
					enter_drop(ERR_METHOD);
				end
			end
			PH_URI_PRE: begin
				if (is_sp) begin
					cur_role = ROLE_SPACE;
				end else if (is_cr || is_lf) begin
					enter_drop(ERR_VERSION);
				end else begin
					cur_role  = ROLE_URI;
					prs_phase = PH_URI;
				end
			end
			PH_URI: begin
				if (is_sp) begin
					cur_role  = ROLE_SPACE;
					cur_last  = 1'b1;
					prs_phase = PH_VER_PRE;
				end else if (is_cr || is_lf) begin
					enter_drop(ERR_VERSION);
				end else begin
					cur_role = ROLE_URI;
				end
			end
			PH_VER_PRE: begin
				if (is_sp) begin
					cur_role = ROLE_SPACE;
				end else begin
					prs_phase = PH_VERSION;
					version_byte(b);
				end
			end
			PH_VERSION: begin
				version_byte(b);
			end
			PH_REQ_END: begin
				if (is_sp) begin
					cur_role = ROLE_SPACE;
				end else if (is_cr) begin
					cur_role = ROLE_EOL;
				end else if (is_lf) begin
					cur_role  = ROLE_EOL;
					cur_last  = 1'b1;
					prs_phase = PH_NAME;
					start_line();
				end else begin
					enter_drop(ERR_VERSION);
				end
			end
			PH_NAME: begin
				if (is_cr) begin
					cur_role = prs_line_empty ? ROLE_BLANK : ROLE_EOL;
				end else if (is_lf) begin
					end_line();
				end else if (b == CH_COLON) begin
					cur_role       = ROLE_NAME;
					cur_last       = 1'b1;
					prs_line_empty = 1'b0;
					if (prs_name_ok && prs_name_idx == 4'd14) begin
						// a repeated content-length is ignored
						if (prs_len_seen) begin
							prs_name_ok = 1'b0;
						end else begin
							prs_len_seen = 1'b1;
							prs_len      = '0;
						end
					end else begin
						prs_name_ok = 1'b0;
					end
					prs_phase = PH_VAL_OWS;
				end else begin
					cur_role       = ROLE_NAME;
					prs_line_empty = 1'b0;
					if (prs_name_ok) begin
						folded = (b >= CH_UP_A && b <= CH_UP_Z) ? b + 8'd32 : b;
						if (prs_name_idx < 4'd14 &&
						    folded == LENGTH_TAG[8*(13-prs_name_idx) +: 8]) begin
							prs_name_idx = prs_name_idx + 4'd1;
						end else begin
							prs_name_ok = 1'b0;
						end
					end
				end
			end
			PH_VAL_OWS: begin
				if (is_sp || b == CH_TAB) begin
					cur_role = ROLE_SPACE;
				end else if (is_cr) begin
					cur_role = ROLE_EOL;
				end else if (is_lf) begin
					end_line();
				end else begin
					prs_phase = PH_VALUE;
					value_byte(b);
				end
			end
			PH_VALUE: begin
				if (is_cr) begin
					cur_role    = ROLE_EOL;
					prs_name_ok = 1'b0;
				end else if (is_lf) begin
					end_line();
				end else begin
					value_byte(b);
				end
			end
			PH_BODY: begin
				cur_role      = ROLE_BODY;
				prs_remaining = prs_remaining - 1'b1;
				if (prs_remaining == 0) begin
					cur_last  = 1'b1;
					cur_done  = 1'b1;
					prs_phase = PH_DROP;
				end
			end
			default: begin
				cur_role  = ROLE_DROP;
				prs_phase = PH_DROP;
			end
		endcase
		w.role   = cur_role;
		w.last   = cur_last;
		w.method = prs_method;
		w.major  = prs_major;
		w.minor  = prs_minor;
		w.length = (prs_len > 32'hffff_ffff) ? 32'hffff_ffff : 32'(prs_len);
		w.err    = prs_err;
		w.done   = cur_done;
		return w;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void report_mismatch(input string what, input token_word_t want,
	                                        input token_word_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("mismatch on result word %0d: %s", n_results, what);
			$display("  expected role=%0d last=%0d method=%0d ver=%0d.%0d len=%0d err=%0d done=%0d",
			         want.role, want.last, want.method, want.major, want.minor,
			         want.length, want.err, want.done);
			$display("  actual   role=%0d last=%0d method=%0d ver=%0d.%0d len=%0d err=%0d done=%0d",
			         got.role, got.last, got.method, got.major, got.minor,
			         got.length, got.err, got.done);
		end
	endfunction

	// both channels are watched at the rising edge; an accepted input word is
	// predicted before any result of the same edge is checked
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending",
			         cycle_count, expected_words.size());
			$display("RESULT: ERROR");
			$finish;
		end else if (arst_n) begin
			if (in_valid && !in_stall) begin
				want_word = predict_word(data_byte, request_start);
				n_sent++;
				if (want_word.role != ROLE_DROP) begin
					n_parsed++;
				end
				// typed rows replace the prediction with the value read off by hand
				if (row_typed) begin
					want_word = row_want;
				end
				expected_words.push_back(want_word);
			end
			if (out_valid && !out_stall) begin
				seen_word.role   = role_t'(byte_role);
				seen_word.last   = token_last;
				seen_word.method = method_code;
				seen_word.major  = version_major;
				seen_word.minor  = version_minor;
				seen_word.length = body_length;
				seen_word.err    = err_t'(error_code);
				seen_word.done   = request_done;
				n_results++;
				n_done        += seen_word.done;
				n_body        += (seen_word.role == ROLE_BODY);
				n_blank       += (seen_word.role == ROLE_BLANK);
				n_bad_method  += (seen_word.err == ERR_METHOD);
				n_bad_version += (seen_word.err == ERR_VERSION);
				if (expected_words.size() == 0) begin
					report_mismatch("result word with nothing pending", seen_word, seen_word);
				end else begin
					want_word  = expected_words.pop_front();
					bad_fields = "";
					if (seen_word.role !== want_word.role) bad_fields = {bad_fields, " role"};
					if (seen_word.last !== want_word.last) bad_fields = {bad_fields, " last"};
					if (seen_word.method !== want_word.method) bad_fields = {bad_fields, " method"};
					if (seen_word.major !== want_word.major) bad_fields = {bad_fields, " major"};
					if (seen_word.minor !== want_word.minor) bad_fields = {bad_fields, " minor"};
					if (seen_word.length !== want_word.length) bad_fields = {bad_fields, " length"};
					if (seen_word.err !== want_word.err) bad_fields = {bad_fields, " error"};
					if (seen_word.done !== want_word.done) bad_fields = {bad_fields, " done"};
					if (bad_fields != "") begin
						report_mismatch({"wrong", bad_fields}, want_word, seen_word);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// the result side stalls in stretches: none, light random, periodic, heavy random
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
			STALL_PERIODIC: out_stall <= (stall_left % 3 == 0);
			default:        out_stall <= ($urandom_range(0, 99) < 75);
		endcase
	end

	// ---------------------------------------------------------------- sender

	// one input word; bursts of random length with idle gaps between them
	task automatic send_word(input logic [7:0] b, input logic s, input logic typed,
	                         input token_word_t want);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
			                                         : $urandom_range(1, 16);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		request_start <= s;
		row_typed     <= typed;
		row_want      <= want;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		burst_left--;
		@(negedge clk);
	endtask

	// hold the input off until every pending result word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_words.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic add_row(input logic [7:0] b, input logic s, input logic typed,
	                       input token_word_t want);
		stim_row_t row;
		row.b     = b;
		row.start = s;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	task automatic add_text_rows(input string text);
		for (int i = 0; i < text.len(); i++) begin
			add_row(text[i], i == 0, 1'b0, '0);
		end
	endtask

	function automatic token_word_t typed_word(input role_t role, input logic last,
	                                           input logic [3:0] method, input logic [3:0] major,
	                                           input logic [3:0] minor, input err_t err,
	                                           input logic done);
		token_word_t w;
		w.role   = role;
		w.last   = last;
		w.method = method;
		w.major  = major;
		w.minor  = minor;
		w.length = 32'd0;
		w.err    = err;
		w.done   = done;
		return w;
	endfunction

	task automatic push_byte(input logic [7:0] c);
		request_bytes.push_back(c);
		request_starts.push_back(1'b0);
	endtask

	task automatic push_text(input string text);
		for (int i = 0; i < text.len(); i++) begin
			push_byte(text[i]);
		end
	endtask

	task automatic push_line_end();
		if ($urandom_range(0, 9) < 7) begin
			push_byte(CH_CR);
		end
		push_byte(CH_LF);
	endtask

	// one random request: mostly well formed with random content, some noise,
	// some cut short or with a corrupted byte
	task automatic compose_request();
		int         kind;
		int         pick;
		int         value;
		int         body_len;
		logic       length_taken;
		logic       huge;
		logic [7:0] c;
		request_bytes.delete();
		request_starts.delete();
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			// raw noise with scattered request starts
			repeat ($urandom_range(1, 12)) begin
				request_bytes.push_back(8'($urandom_range(0, 255)));
				request_starts.push_back($urandom_range(0, 4) == 0);
			end
			return;
		end
		body_len     = 0;
		length_taken = 1'b0;
		pick = $urandom_range(0, METHOD_COUNT - 1);
		for (int p = 0; p < METHOD_LEN[pick]; p++) begin
			push_byte(METHOD_NAME[pick][8*(METHOD_LEN[pick]-1-p) +: 8]);
		end
		repeat ($urandom_range(1, 2)) push_byte(CH_SP);
		// an empty uri now and then lets the version land in the uri slot
		repeat (($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6)) begin
			push_byte(8'($urandom_range(33, 126)));
		end
		repeat (($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 2)) push_byte(CH_SP);
		push_text("HTTP/");
		push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
		push_byte(CH_DOT);
		push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 9) == 0) begin
			push_byte(CH_SP);
		end
		push_line_end();
		repeat ($urandom_range(0, 3)) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				// content-length in random letter case
				for (int i = 13; i >= 0; i--) begin
					c = LENGTH_TAG[8*i +: 8];
					if (c >= CH_LOW_A && c <= CH_LOW_Z && $urandom_range(0, 1)) begin
						c = c - 8'd32;
					end
					push_byte(c);
				end
				push_byte(CH_COLON);
				repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
				huge = ($urandom_range(0, 9) == 0);
				if (huge) begin
					// 9 to 13 random digits, which can run past the saturation point
					repeat ($urandom_range(9, 13)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
					value = $urandom_range(0, 20);
				end else begin
					value = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60)
					                                   : $urandom_range(0, 12);
					push_text($sformatf("%0d", value));
				end
				if ($urandom_range(0, 9) == 0) begin
					push_text("x7");
				end
				if (!length_taken) begin
					length_taken = 1'b1;
					body_len     = value;
				end
			end else if (pick < 7) begin
				// names that only start like content-length
				push_text(($urandom_range(0, 1)) ? "Content-Len" : "content-lengths");
				push_byte(CH_COLON);
				push_text($sformatf("%0d", $urandom_range(0, 99)));
			end else if (pick < 9) begin
				repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(97, 122)));
				push_byte(CH_COLON);
				repeat ($urandom_range(0, 2)) push_byte(CH_SP);
				repeat ($urandom_range(0, 8)) push_byte(8'($urandom_range(33, 126)));
			end else begin
				// a header line without a colon
				repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(65, 90)));
			end
			push_line_end();
		end
		push_line_end();
		repeat (body_len) push_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 99) < 6) begin
			request_bytes[$urandom_range(0, request_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		end
		if ($urandom_range(0, 99) < 4) begin
			while (request_bytes.size() > 1 && $urandom_range(0, 3) != 0) begin
				void'(request_bytes.pop_back());
				void'(request_starts.pop_back());
			end
		end
		// a request sent without its start marker is dropped, unless the one before it was left unfinished
		request_starts[0] = ($urandom_range(0, 29) != 0);
	endtask

	// ---------------------------------------------------------------- main flow

	initial begin
		int word_goal;
		clear_parser();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed table: bad method after reset, byte extremes, missing
		// version, and a minimal request ending on its blank line
		add_row(8'h58, 1'b1, 1'b1,
		        typed_word(ROLE_DROP, 1'b0, 4'd0, 4'd0, 4'd0, ERR_METHOD, 1'b0));
		add_row(8'h00, 1'b0, 1'b1,
		        typed_word(ROLE_DROP, 1'b0, 4'd0, 4'd0, 4'd0, ERR_METHOD, 1'b0));
		add_row(8'hff, 1'b1, 1'b1,
		        typed_word(ROLE_DROP, 1'b0, 4'd0, 4'd0, 4'd0, ERR_METHOD, 1'b0));
		add_text_rows("GET x");
		add_row(CH_LF, 1'b0, 1'b1,
		        typed_word(ROLE_DROP, 1'b0, 4'd2, 4'd0, 4'd0, ERR_VERSION, 1'b0));
		add_text_rows("PUT / HTTP/9.0\n");
		add_row(CH_LF, 1'b0, 1'b1,
		        typed_word(ROLE_BLANK, 1'b1, 4'd5, 4'd9, 4'd0, ERR_NONE, 1'b1));
		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].b, directed_rows[i].start,
			          directed_rows[i].typed, directed_rows[i].want);
		end
		wait_drained();

		// random requests until enough words have been sent
		word_goal = n_sent + RANDOM_WORDS;
		while (n_sent < word_goal) begin
			compose_request();
			foreach (request_bytes[i]) begin
				send_word(request_bytes[i], request_starts[i], 1'b0, '0);
			end
			n_requests++;
			if (n_requests % DRAIN_EVERY == 0) begin
				wait_drained();
			end
		end

		in_valid <= 1'b0;
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		// keep the clock running to catch any stray result word
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_words.size() != 0) begin
			mismatches++;
		end
		$display("covered %0d result words (%0d parsed) over %0d random requests: %0d done, %0d body, %0d blank",
		         n_results, n_parsed, n_requests, n_done, n_body, n_blank);
		$display("words under error: %0d bad method, %0d bad version; %0d mismatches",
		         n_bad_method, n_bad_version, mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* http_request_byte_tokenizer.f */
sv/hrbt_pkg.sv
sv/http_request_byte_tokenizer.sv
bench/http_request_byte_tokenizer_tb.sv
